// ===== src/tmvp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmvp_pkg
// Shared types and constants of the tridiagonal matrix-vector product block.
// ----------------------------------------------------------------------------
package tmvp_pkg;

   localparam int MAX_ROWS    = 1024;
   localparam int ADDR_W      = $clog2(MAX_ROWS);
   localparam int ROW_W       = 10;
   localparam int LEN_W       = 11;
   localparam int COEF_W      = 16;
   localparam int VAL_W       = 32;
   localparam int SUM_W       = 34;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int REQ_DATA_W  = 112;
   localparam int RSP_DATA_W  = 48;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCUMULATE = 2'd2;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_VECTOR = 1'b1;

   typedef struct packed {
      logic [LEN_W-1:0] vector_length;
      logic             transpose_mode;
      logic             accumulate_mode;
   } cfg_type;

   // One operation for the back end: a table row write or one result row.
   // For a write, d0/d1/d2 are sub/main/super; otherwise left/centre/right.
   typedef struct packed {
      logic                     is_write;
      logic [ROW_W-1:0]         row;
      logic signed [COEF_W-1:0] d0;
      logic signed [COEF_W-1:0] d1;
      logic signed [COEF_W-1:0] d2;
      logic signed [VAL_W-1:0]  prior;
      logic                     has_left;
      logic                     has_right;
      logic                     last;
   } job_type;

endpackage

// ===== src/tmvp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmvp_front
// Accepts transactions, tracks the vector window and issues back-end jobs.
// ----------------------------------------------------------------------------
module tmvp_front (
   input  logic                            clock,
   input  logic                            reset,
   input  tmvp_pkg::cfg_type               cfg,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tmvp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   output logic                            push_valid,
   input  logic                            push_ready,
   output tmvp_pkg::job_type               push_data
);
   import tmvp_pkg::*;

   logic [ROW_W-1:0]         f_row;
   logic signed [COEF_W-1:0] f_sub, f_main, f_super, f_vec;
   logic signed [VAL_W-1:0]  f_prior;

   logic signed [COEF_W-1:0] prev_ff, prev_in, cur_ff, cur_in;
   logic signed [VAL_W-1:0]  held_ff, held_in;
   logic [LEN_W-1:0]         count_ff, count_in;
   logic                     pend_v_ff, pend_v_in;
   job_type                  pend_ff, pend_in;

   logic [LEN_W-1:0] n_use;
   logic             accept, is_last;
   job_type          job_a, job_b, job_w;

   assign f_row   = req_tdata[9:0];
   assign f_sub   = req_tdata[25:10];
   assign f_main  = req_tdata[41:26];
   assign f_super = req_tdata[57:42];
   assign f_vec   = req_tdata[73:58];
   assign f_prior = req_tdata[105:74];

   assign req_tready = !pend_v_ff && push_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (cfg.vector_length == '0) begin
         n_use = LEN_W'(1);
      end else if (32'(cfg.vector_length) > MAX_ROWS) begin
         n_use = LEN_W'(MAX_ROWS);
      end else begin
         n_use = cfg.vector_length;
      end
      is_last = (({1'b0, count_ff} + (LEN_W+1)'(1)) >= {1'b0, n_use});

      job_w           = '0;
      job_w.is_write  = 1'b1;
      job_w.row       = f_row;
      job_w.d0        = f_sub;
      job_w.d1        = f_main;
      job_w.d2        = f_super;

      job_a           = '0;
      job_a.row       = ROW_W'(count_ff - LEN_W'(1));
      job_a.d0        = prev_ff;
      job_a.d1        = cur_ff;
      job_a.d2        = f_vec;
      job_a.prior     = held_ff;
      job_a.has_left  = (count_ff > LEN_W'(1));
      job_a.has_right = 1'b1;

      job_b           = '0;
      job_b.row       = ROW_W'(count_ff);
      job_b.d0        = cur_ff;
      job_b.d1        = f_vec;
      job_b.prior     = f_prior;
      job_b.has_left  = (count_ff != '0);
      job_b.last      = 1'b1;
   end

   always_comb begin
      prev_in    = prev_ff;
      cur_in     = cur_ff;
      held_in    = held_ff;
      count_in   = count_ff;
      pend_v_in  = pend_v_ff;
      pend_in    = pend_ff;
      push_valid = 1'b0;
      push_data  = pend_ff;
      if (pend_v_ff) begin
         push_valid = 1'b1;
         if (push_ready) begin
            pend_v_in = 1'b0;
         end
      end else if (accept) begin
         if (req_tuser == CMD_LOAD) begin
            push_valid = (32'(f_row) < MAX_ROWS);
            push_data  = job_w;
         end else begin
            if (count_ff != '0) begin
               push_valid = 1'b1;
               push_data  = job_a;
               if (is_last) begin
                  pend_v_in = 1'b1;
                  pend_in   = job_b;
               end
            end else if (is_last) begin
               push_valid = 1'b1;
               push_data  = job_b;
            end
            if (is_last) begin
               prev_in  = '0;
               cur_in   = '0;
               held_in  = '0;
               count_in = '0;
            end else begin
               prev_in  = cur_ff;
               cur_in   = f_vec;
               held_in  = f_prior;
               count_in = count_ff + LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         cur_ff    <= '0;
         held_ff   <= '0;
         count_ff  <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         prev_ff   <= prev_in;
         cur_ff    <= cur_in;
         held_ff   <= held_in;
         count_ff  <= count_in;
         pend_v_ff <= pend_v_in;
      end
      pend_ff <= pend_in;
   end

endmodule

// ===== src/tmvp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmvp_queue
// Short job FIFO decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module tmvp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tmvp_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tmvp_pkg::job_type pop_data
);
   import tmvp_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/tmvp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmvp_back
// Coefficient tables and the multiply-sum-saturate pipeline.
// ----------------------------------------------------------------------------
module tmvp_back (
   input  logic                            clock,
   input  logic                            reset,
   input  tmvp_pkg::cfg_type               cfg,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  tmvp_pkg::job_type               pop_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tmvp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import tmvp_pkg::*;

   logic [COEF_W-1:0] sub_mem   [MAX_ROWS];
   logic [COEF_W-1:0] main_mem  [MAX_ROWS];
   logic [COEF_W-1:0] super_mem [MAX_ROWS];

   logic              en, do_pop, do_write;
   logic [ADDR_W-1:0] addr_c, addr_sub, addr_super;

   // stage 1: table read data
   logic                     s1_v_ff;
   job_type                  s1_job_ff;
   logic signed [COEF_W-1:0] sub_rd_ff, main_rd_ff, super_rd_ff;

   // stage 2: products
   logic                     s2_v_ff, s2_last_ff;
   logic [ROW_W-1:0]         s2_row_ff;
   logic signed [VAL_W-1:0]  s2_prior_ff;
   logic signed [VAL_W-1:0]  pl_ff, pc_ff, pr_ff, pl_in, pc_in, pr_in;
   logic signed [COEF_W-1:0] coef_l, coef_r;

   // stage 3: sum
   logic                     s3_v_ff, s3_last_ff;
   logic [ROW_W-1:0]         s3_row_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   // output register
   logic                     out_v_ff, out_last_ff;
   logic [ROW_W-1:0]         out_row_ff;
   logic signed [VAL_W-1:0]  out_val_ff, out_val_in;

   assign en        = !out_v_ff || rsp_tready;
   assign pop_ready = en;
   assign do_pop    = pop_valid && en;
   assign do_write  = do_pop && pop_data.is_write;

   assign addr_c     = ADDR_W'(pop_data.row);
   assign addr_sub   = cfg.transpose_mode ? addr_c + ADDR_W'(1) : addr_c;
   assign addr_super = cfg.transpose_mode ? addr_c - ADDR_W'(1) : addr_c;

   always_ff @(posedge clock) begin
      if (do_write) begin
         sub_mem[addr_c] <= pop_data.d0;
      end
      if (en) begin
         sub_rd_ff <= sub_mem[addr_sub];
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         main_mem[addr_c] <= pop_data.d1;
      end
      if (en) begin
         main_rd_ff <= main_mem[addr_c];
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         super_mem[addr_c] <= pop_data.d2;
      end
      if (en) begin
         super_rd_ff <= super_mem[addr_super];
      end
   end

   always_comb begin
      coef_l = cfg.transpose_mode ? super_rd_ff : sub_rd_ff;
      coef_r = cfg.transpose_mode ? sub_rd_ff : super_rd_ff;
      pl_in  = s1_job_ff.has_left  ? coef_l * s1_job_ff.d0 : VAL_W'(0);
      pc_in  = main_rd_ff * s1_job_ff.d1;
      pr_in  = s1_job_ff.has_right ? coef_r * s1_job_ff.d2 : VAL_W'(0);
      sum_in = SUM_W'(pl_ff) + SUM_W'(pc_ff) + SUM_W'(pr_ff)
             + (cfg.accumulate_mode ? SUM_W'(s2_prior_ff) : SUM_W'(0));
      if (sum_ff[SUM_W-1:VAL_W-1] == '0 || sum_ff[SUM_W-1:VAL_W-1] == '1) begin
         out_val_in = sum_ff[VAL_W-1:0];
      end else if (sum_ff[SUM_W-1]) begin
         out_val_in = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         out_val_in = {1'b0, {(VAL_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff  <= pop_valid && !pop_data.is_write;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         out_v_ff <= s3_v_ff;
      end
      if (en) begin
         s1_job_ff   <= pop_data;
         pl_ff       <= pl_in;
         pc_ff       <= pc_in;
         pr_ff       <= pr_in;
         s2_row_ff   <= s1_job_ff.row;
         s2_last_ff  <= s1_job_ff.last;
         s2_prior_ff <= s1_job_ff.prior;
         sum_ff      <= sum_in;
         s3_row_ff   <= s2_row_ff;
         s3_last_ff  <= s2_last_ff;
         out_val_ff  <= out_val_in;
         out_row_ff  <= s3_row_ff;
         out_last_ff <= s3_last_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-VAL_W-ROW_W){1'b0}}, out_row_ff, out_val_ff};

endmodule

// ===== src/tridiagonal_matrix_vector_product.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tridiagonal_matrix_vector_product
// Streaming tridiagonal matrix times vector with Q4.12 inputs, Q8.24 results.
// ----------------------------------------------------------------------------
// One request transaction is taken per clock while the queue has room and no
// second result is pending. Other requests yield at most one result; the last
// element of a vector of two or more yields two and holds the request side
// until the second is queued. The result side sustains one transaction per
// clock while rsp_tready is high, set by the single read port of each
// coefficient table and the one-row-per-cycle multiply pipeline. A four-entry
// job queue lets the request side run on while results are back-pressured.
module tridiagonal_matrix_vector_product (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tmvp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tmvp_pkg::LEN_W-1:0]       csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // row_index, sub_coef, main_coef, super_coef, vector_value, prior_value
   input  logic [tmvp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // result_value, result_index
   output logic [tmvp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);
   import tmvp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push_valid, push_ready, pop_valid, pop_ready;
   job_type push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LENGTH:     cfg_in.vector_length   = csr_wdata;
            CSR_TRANSPOSE:  cfg_in.transpose_mode  = csr_wdata[0];
            CSR_ACCUMULATE: cfg_in.accumulate_mode = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{vector_length: LEN_W'(1), transpose_mode: 1'b0,
                     accumulate_mode: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tmvp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tmvp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tmvp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
